@@ src/rjb_pkg.sv @@
// Package: shared constants, types and byte functions for the Rijndael-256 encryptor.
`timescale 1ns / 1ps
package rjb_pkg;
	localparam int MaxRoundsDefault = 14;
	localparam int BlockBits        = 256;
	localparam int CountBits        = 4;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_ENCRYPT = 1'b1;

	typedef logic [7:0] byte_t;
	typedef logic [BlockBits-1:0] block_t;

	// Rijndael S-box
	localparam byte_t SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic byte_t xtime(input byte_t a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// SubBytes, ShiftRows (offsets 0,1,3,4), optional MixColumns; byte i = row i%4, col i/4
	function automatic block_t round_func(input block_t st, input logic mix);
		block_t t;
		block_t m;
		byte_t a0, a1, a2, a3, all;
		int src;
		for (int c = 0; c < 8; c++) begin
			for (int r = 0; r < 4; r++) begin
				src = 4 * ((c + ((r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 3 : 4)) % 8) + r;
				t[8*(4*c+r) +: 8] = SBOX[st[8*src +: 8]];
			end
		end
		m = t;
		for (int c = 0; c < 8; c++) begin
			a0 = t[8*(4*c)   +: 8];
			a1 = t[8*(4*c+1) +: 8];
			a2 = t[8*(4*c+2) +: 8];
			a3 = t[8*(4*c+3) +: 8];
			all = a0 ^ a1 ^ a2 ^ a3;
			m[8*(4*c)   +: 8] = a0 ^ all ^ xtime(a0 ^ a1);
			m[8*(4*c+1) +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
			m[8*(4*c+2) +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
			m[8*(4*c+3) +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
		end
		round_func = mix ? m : t;
	endfunction
endpackage

@@ src/rjb_key_mem.sv @@
// Round key memory: one 256-bit row per round, synchronous registered read.
`timescale 1ns / 1ps
module rjb_key_mem import rjb_pkg::*; #(
	parameter int MAX_ROUNDS = MaxRoundsDefault
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [$clog2(MAX_ROUNDS+1)-1:0] wr_addr,
	input  block_t                        wr_data,
	input  logic [$clog2(MAX_ROUNDS+1)-1:0] rd_addr,
	output block_t                        rd_data
);
	block_t mem [MAX_ROUNDS+1];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end
endmodule

@@ src/rijndael256_block_encrypt.sv @@
// Top level: Rijndael-256 block encryptor with stored round keys and stream ports.
// Sequence: a key load is stored at its acceptance edge; an encryption adds key 0 after acceptance,
//   then runs one round per cycle and loads the result into the output register.
// A new block is accepted only in IDLE, once the previous block has left the datapath; one round-key
//   memory read per cycle; a finished block waits in the output register, or in DONE while that is full.
// Reset (arst_n, asynchronous, low): idle, round_count = 14, no result held; key memory is not cleared.
`timescale 1ns / 1ps
module rijndael256_block_encrypt import rjb_pkg::*; #(
	parameter int MAX_ROUNDS = MaxRoundsDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [3:0]   cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [263:0] s_tdata,  // key_round[3:0], word_a, word_b, word_c, word_d, pad[3:0]
	input  logic         s_tuser,  // op
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [255:0] m_tdata   // cipher_a, cipher_b, cipher_c, cipher_d
);
	localparam int AW = $clog2(MAX_ROUNDS + 1);

	typedef enum logic [1:0] {IDLE, KEY0, ROUND, DONE} state_t;

	state_t               state_q;
	logic [CountBits-1:0] round_count_q;
	logic [CountBits-1:0] round_q;
	logic [CountBits-1:0] last_q;
	block_t               block_q;
	block_t               block_nxt;
	block_t               out_q;
	logic [AW-1:0]        rd_addr;
	block_t               rkey;
	logic                 in_acc;
	logic                 key_wr;
	logic [3:0]           key_round;
	logic [CountBits-1:0] n_eff;
	logic                 out_free;
	logic                 out_ld;

	assign key_round = s_tdata[3:0];
	assign s_tready  = (state_q == IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign key_wr    = in_acc && (s_tuser == OP_LOAD) && (32'(key_round) <= MAX_ROUNDS);

	// output register free this cycle, and load of a finished block
	assign out_free = !m_tvalid || m_tready;
	assign out_ld   = out_free && (((state_q == ROUND) && (round_q == last_q)) ||
		(state_q == DONE));

	// clamp the configured round count
	always_comb begin
		n_eff = round_count_q;
		if (round_count_q == '0) n_eff = CountBits'(1);
		if (32'(round_count_q) > MAX_ROUNDS) n_eff = CountBits'(MAX_ROUNDS);
	end

	// read address: key 0 on acceptance, next round key while rounds run
	always_comb begin
		rd_addr = '0;
		if ((state_q == KEY0) || ((state_q == ROUND) && (round_q != last_q))) begin
			rd_addr = AW'(round_q + CountBits'(1));
		end
	end

	rjb_key_mem #(.MAX_ROUNDS(MAX_ROUNDS)) u_keys (
		.clk     (clk),
		.wr_en   (key_wr),
		.wr_addr (key_round[AW-1:0]),
		.wr_data (s_tdata[259:4]),
		.rd_addr (rd_addr),
		.rd_data (rkey)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_count_q <= CountBits'(14);
		end else if (cfg_we) begin
			round_count_q <= cfg_wdata;
		end
	end

	// round sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			round_q  <= '0;
			last_q   <= '0;
			m_tvalid <= 1'b0;
		end else begin
			m_tvalid <= out_ld || (m_tvalid && !m_tready);
			case (state_q)
				IDLE: begin
					if (in_acc && s_tuser == OP_ENCRYPT) begin
						state_q <= KEY0;
						round_q <= '0;
						last_q  <= n_eff;
					end
				end
				KEY0: begin
					state_q <= ROUND;
					round_q <= CountBits'(1);
				end
				ROUND: begin
					if (round_q == last_q) begin
						if (out_free) begin
							state_q <= IDLE;
							round_q <= '0;
						end else begin
							state_q <= DONE;
						end
					end else begin
						round_q <= round_q + CountBits'(1);
					end
				end
				DONE: begin
					if (out_free) begin
						state_q <= IDLE;
						round_q <= '0;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// one round of the working block with this cycle's key
	assign block_nxt = round_func(block_q, round_q != last_q) ^ rkey;

	// block datapath: initial key add, then one round per cycle
	always_ff @(posedge clk) begin
		if (in_acc && s_tuser == OP_ENCRYPT) begin
			block_q <= s_tdata[259:4];
		end else if (state_q == KEY0) begin
			block_q <= block_q ^ rkey;
		end else if (state_q == ROUND) begin
			block_q <= block_nxt;
		end
	end

	// result register, loaded from the last round or from a parked block
	always_ff @(posedge clk) begin
		if (out_ld) begin
			out_q <= (state_q == DONE) ? block_q : block_nxt;
		end
	end

	assign m_tdata = out_q;

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != IDLE) |-> !s_tready)
		else $error("input accepted while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while waiting");
	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ROUND) |-> (round_q <= last_q))
		else $error("round counter past last round");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_tuser == OP_ENCRYPT) |=> (state_q == KEY0))
		else $error("encryption did not start");
`endif
endmodule
